// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== src/grc_pkg.sv =====
// Types, constants and tables for the grid ray caster.
package grc_pkg;

  localparam int TILE_PIXELS   = 64;
  localparam int MAP_COLUMNS   = 32;
  localparam int MAP_ROWS      = 16;
  localparam int RAY_COUNT     = 1024;
  localparam int TQ            = TILE_PIXELS * 256;
  localparam int TQ_SH         = $clog2(TQ);
  localparam int DL_W          = TQ_SH + 1;
  localparam int ROW_W         = $clog2(MAP_ROWS);
  localparam int COL_W         = $clog2(MAP_COLUMNS);
  localparam int ADDR_W        = ROW_W + COL_W;
  localparam int CELLS         = MAP_ROWS * MAP_COLUMNS;
  localparam int MAP_W_PIX     = MAP_COLUMNS * TQ;
  localparam int MAP_H_PIX     = MAP_ROWS * TQ;
  localparam int CORDIC_STEPS  = 15;
  localparam int CORDIC_START  = 9949;
  localparam int QUARTER_TURN  = 16384;
  localparam int HALF_TURN     = 32768;
  localparam int THREE_QUARTER = 49152;
  localparam int PD_W          = 20;
  localparam int PD_RESET      = 227021;
  localparam int DIV_STEPS     = 30;
  localparam int SQRT_STEPS    = 21;
  localparam int SQRT_TOP      = 40;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_CAST   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  cell_row;
    logic [4:0]  cell_col;
    logic [7:0]  cell_value;
    logic [9:0]  ray_index;
    logic [18:0] player_x;
    logic [17:0] player_y;
    logic [15:0] player_angle;
  } in_t;

  typedef struct packed {
    logic [15:0] ray_angle;
    logic        hit_found;
    logic [18:0] hit_x;
    logic [17:0] hit_y;
    logic [19:0] hit_distance;
    logic [7:0]  wall_content;
    logic        vert_side;
  } out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ATAN, S_ANGLE, S_SINCOS, S_QUAD, S_MUL, S_DIVLD, S_DIV,
    S_WSET, S_WCHK, S_WRD, S_SQ, S_PICK, S_SQRT, S_FIN
  } state_t;

  // atan(2^-i) in turn units, 65536 per turn
  function automatic logic signed [16:0] turn_atan(input logic [3:0] idx);
    logic signed [16:0] v;
    v = '0;
    unique case (idx)
      4'd0:  v = 17'sd8192;
      4'd1:  v = 17'sd4836;
      4'd2:  v = 17'sd2555;
      4'd3:  v = 17'sd1297;
      4'd4:  v = 17'sd651;
      4'd5:  v = 17'sd326;
      4'd6:  v = 17'sd163;
      4'd7:  v = 17'sd81;
      4'd8:  v = 17'sd41;
      4'd9:  v = 17'sd20;
      4'd10: v = 17'sd10;
      4'd11: v = 17'sd5;
      4'd12: v = 17'sd3;
      4'd13: v = 17'sd1;
      4'd14: v = 17'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/grid_ray_caster_unit.sv =====
// Grid ray caster: tile map store, CORDIC, serial divider, grid walker, root.
//
// Input channel (in_valid / in_stall / in_data) carries one item per handshake.
// kind 0 writes one map cell as it is accepted; it produces no result.
// kind 1 casts one ray and produces one result item on the out_ channel.
// A cast runs on one shared datapath under a sequencer: 15 atan CORDIC steps
// (skipped for the centre column or a zero plane distance), 15 sin/cos steps,
// up to four multiply-and-divide jobs on one multiplier and a one-bit-per-cycle
// divider, two grid walks (one map read per crossing), squared distance on the
// same multiplier and a bit-serial square root (skipped if neither walk hits).
// in_stall is high during a cast; the next item is taken once it finishes.
// The result sits in an output register; a stalled receiver holds it there,
// and a new item may be accepted meanwhile, but the next cast waits at its end
// until the register is free.
// plane_distance is written on cfg_valid / cfg_ready; cfg_ready is always high.
// After reset the map store is cleared one cell a cycle, all 512 cells, and
// in_stall stays high meanwhile.
`include "assert_macros.svh"

module grid_ray_caster_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  grc_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output grc_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [grc_pkg::PD_W-1:0]  cfg_data
);
  import grc_pkg::*;

  state_t state_r, state_nxt;
  logic [4:0]        cnt_r;
  logic [ADDR_W-1:0] clr_r;
  logic [PD_W-1:0]   pd_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [7:0] map_mem [CELLS];
  logic [7:0] rd_r;

  in_t  in_r;
  logic signed [23:0] cx_r, cy_r;
  logic signed [16:0] cz_r;
  logic [15:0] ang_r;
  logic        down_r, right_r, hval_r, vval_r;
  logic [16:0] ac_r, as_r;
  logic [18:0] yl_r;
  logic [19:0] xl_r;
  logic [DL_W-1:0] dly_r, dlx_r;
  logic [39:0] prod_r;
  logic [29:0] dq_r;
  logic [17:0] drem_r;
  logic [1:0]  job_r;
  logic [29:0] xo_r, xs_r, yo_r, ys_r;
  logic        wsel_r;
  logic signed [32:0] wx_r, wy_r, sx_r, sy_r;
  logic        oob_r;
  logic        hhit_r, vhit_r, take_v_r;
  logic [19:0] hx_r, vx_r;
  logic [18:0] hy_r, vy_r;
  logic [7:0]  hcont_r, vcont_r;
  logic [40:0] hd_r, vd_r;
  logic [41:0] sq_v_r, sq_r_r, sq_b_r;

  logic in_acc, out_take, can_load;
  logic mem_we;
  logic [ADDR_W-1:0] mem_wa, rd_addr_c;
  logic [7:0] mem_wd;

  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // angle offset numerator: column offset in Q.8
  logic signed [10:0] col_off_c;
  logic signed [18:0] num_c;
  assign col_off_c = $signed({1'b0, in_data.ray_index}) - $signed(11'(RAY_COUNT / 2));
  assign num_c     = {col_off_c, 8'b0};

  // shared CORDIC rotation step
  logic signed [23:0] xs_c, ys_c, x_n, y_n;
  logic signed [16:0] ta_c, z_n;
  logic neg_c;
  assign xs_c  = cx_r >>> cnt_r[3:0];
  assign ys_c  = cy_r >>> cnt_r[3:0];
  assign ta_c  = turn_atan(cnt_r[3:0]);
  assign neg_c = (state_r == S_ATAN) ? !cy_r[23] : cz_r[16];
  assign x_n   = neg_c ? cx_r + ys_c : cx_r - ys_c;
  assign y_n   = neg_c ? cy_r - xs_c : cy_r + xs_c;
  assign z_n   = neg_c ? cz_r + ta_c : cz_r - ta_c;

  logic [15:0] ang_c;
  assign ang_c = in_r.player_angle + cz_r[15:0];

  // quadrant fold and direction
  logic signed [23:0] c_c, s_c;
  logic [16:0] ac_c, as_c;
  logic down_c, right_c, hval_c, vval_c;
  logic [18:0] yl_c;
  logic [19:0] xl_c;
  logic [DL_W-1:0] dly_c, dlx_c;
  always_comb begin
    unique case (ang_r[15:14])
      2'd0:    begin c_c = cx_r;  s_c = cy_r;  end
      2'd1:    begin c_c = -cy_r; s_c = cx_r;  end
      2'd2:    begin c_c = -cx_r; s_c = -cy_r; end
      default: begin c_c = cy_r;  s_c = -cx_r; end
    endcase
    ac_c    = 17'(c_c[23] ? -c_c : c_c);
    as_c    = 17'(s_c[23] ? -s_c : s_c);
    down_c  = ang_r != 16'd0 && ang_r < 16'(HALF_TURN);
    right_c = ang_r < 16'(QUARTER_TURN) || ang_r > 16'(THREE_QUARTER);
    hval_c  = ang_r != 16'd0 && ang_r != 16'(HALF_TURN) && as_c != '0;
    vval_c  = ang_r != 16'(QUARTER_TURN) && ang_r != 16'(THREE_QUARTER) && ac_c != '0;
    yl_c    = 19'((19'(in_r.player_y) >> TQ_SH) << TQ_SH) + (down_c ? 19'(TQ) : 19'd0);
    xl_c    = 20'((20'(in_r.player_x) >> TQ_SH) << TQ_SH) + (right_c ? 20'(TQ) : 20'd0);
    dly_c   = down_c ? DL_W'(TQ) - DL_W'(in_r.player_y[TQ_SH-1:0])
                     : DL_W'(in_r.player_y[TQ_SH-1:0]);
    dlx_c   = right_c ? DL_W'(TQ) - DL_W'(in_r.player_x[TQ_SH-1:0])
                      : DL_W'(in_r.player_x[TQ_SH-1:0]);
  end

  // squared-distance operands
  logic signed [20:0] hdx_s, hdy_s, vdx_s, vdy_s;
  logic [19:0] sq_op_c;
  assign hdx_s = $signed({1'b0, hx_r}) - $signed({2'b0, in_r.player_x});
  assign hdy_s = $signed({2'b0, hy_r}) - $signed({3'b0, in_r.player_y});
  assign vdx_s = $signed({1'b0, vx_r}) - $signed({2'b0, in_r.player_x});
  assign vdy_s = $signed({2'b0, vy_r}) - $signed({3'b0, in_r.player_y});
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_op_c = 20'(hdx_s[20] ? -hdx_s : hdx_s);
      2'd1:    sq_op_c = 20'(hdy_s[20] ? -hdy_s : hdy_s);
      2'd2:    sq_op_c = 20'(vdx_s[20] ? -vdx_s : vdx_s);
      default: sq_op_c = 20'(vdy_s[20] ? -vdy_s : vdy_s);
    endcase
  end

  // shared multiplier
  logic [19:0] mul_a_c, mul_b_c;
  logic [39:0] mul_p_c;
  always_comb begin
    if (state_r == S_SQ) begin
      mul_a_c = sq_op_c;
      mul_b_c = sq_op_c;
    end else begin
      case (job_r)
        2'd0:    mul_a_c = 20'(dly_r);
        2'd2:    mul_a_c = 20'(dlx_r);
        default: mul_a_c = 20'(TQ);
      endcase
      mul_b_c = job_r[1] ? 20'(as_r) : 20'(ac_r);
    end
  end
  assign mul_p_c = mul_a_c * mul_b_c;

  // restoring divider, one quotient bit a cycle
  logic [16:0] dsor_c;
  logic [17:0] rsh_c, rnew_c;
  logic        dge_c;
  assign dsor_c = job_r[1] ? ac_r : as_r;
  assign rsh_c  = {drem_r[16:0], dq_r[29]};
  assign dge_c  = rsh_c >= {1'b0, dsor_c};
  assign rnew_c = dge_c ? rsh_c - {1'b0, dsor_c} : rsh_c;

  // walker setup and cell address
  logic signed [32:0] xo_s, xs_s, yo_s, ys_s, tq_s;
  logic signed [32:0] w_x0, w_y0, w_sx, w_sy;
  assign xo_s = $signed({3'b0, xo_r});
  assign xs_s = $signed({3'b0, xs_r});
  assign yo_s = $signed({3'b0, yo_r});
  assign ys_s = $signed({3'b0, ys_r});
  assign tq_s = $signed(33'(TQ));
  always_comb begin
    if (!wsel_r) begin
      w_x0 = $signed(33'(in_r.player_x)) + (right_r ? xo_s : -xo_s);
      w_y0 = $signed(33'(yl_r));
      w_sx = right_r ? xs_s : -xs_s;
      w_sy = down_r ? tq_s : -tq_s;
    end else begin
      w_x0 = $signed(33'(xl_r));
      w_y0 = $signed(33'(in_r.player_y)) + (down_r ? yo_s : -yo_s);
      w_sx = right_r ? tq_s : -tq_s;
      w_sy = down_r ? ys_s : -ys_s;
    end
  end

  logic back_c, inb_c, cell_in_c;
  logic signed [9:0] rowi_c, coli_c;
  logic [7:0] cellv_c;
  assign back_c  = wsel_r ? !right_r : !down_r;
  assign inb_c   = !wx_r[32] && wx_r <= $signed(33'(MAP_W_PIX)) &&
                   !wy_r[32] && wy_r <= $signed(33'(MAP_H_PIX));
  assign rowi_c  = $signed(10'(wy_r >>> TQ_SH)) - $signed(10'(back_c && !wsel_r));
  assign coli_c  = $signed(10'(wx_r >>> TQ_SH)) - $signed(10'(back_c && wsel_r));
  assign cell_in_c = !rowi_c[9] && rowi_c < $signed(10'(MAP_ROWS)) &&
                     !coli_c[9] && coli_c < $signed(10'(MAP_COLUMNS));
  assign rd_addr_c = {rowi_c[ROW_W-1:0], coli_c[COL_W-1:0]};
  assign cellv_c   = oob_r ? 8'd0 : rd_r;

  // square root step
  logic [41:0] sq_rb_c;
  logic        sq_ge_c;
  assign sq_rb_c = sq_r_r + sq_b_r;
  assign sq_ge_c = sq_v_r >= sq_rb_c;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == ADDR_W'(CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc && in_data.kind == KIND_CAST) begin
          state_nxt = (num_c == '0 || pd_r == '0) ? S_ANGLE : S_ATAN;
        end
      end
      S_ATAN:   if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = S_ANGLE;
      S_ANGLE:  state_nxt = S_SINCOS;
      S_SINCOS: if (cnt_r == 5'(CORDIC_STEPS - 1)) state_nxt = S_QUAD;
      S_QUAD:   state_nxt = (hval_c || vval_c) ? S_MUL : S_WSET;
      S_MUL:    state_nxt = S_DIVLD;
      S_DIVLD:  state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          if (job_r == 2'd0 || job_r == 2'd2) state_nxt = S_MUL;
          else if (job_r == 2'd1 && vval_r) state_nxt = S_MUL;
          else state_nxt = S_WSET;
        end
      end
      S_WSET: begin
        if (!wsel_r) state_nxt = hval_r ? S_WCHK : S_WSET;
        else state_nxt = vval_r ? S_WCHK : S_SQ;
      end
      S_WCHK: begin
        if (inb_c) state_nxt = S_WRD;
        else state_nxt = wsel_r ? S_SQ : S_WSET;
      end
      S_WRD: begin
        if (cellv_c != 8'd0) state_nxt = wsel_r ? S_SQ : S_WSET;
        else state_nxt = S_WCHK;
      end
      S_SQ:     if (cnt_r == 5'd4) state_nxt = S_PICK;
      S_PICK:   state_nxt = (hhit_r || vhit_r) ? S_SQRT : S_FIN;
      S_SQRT:   if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = S_FIN;
      S_FIN:    if (can_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = state_r != S_IDLE;
    mem_we   = 1'b0;
    mem_wa   = {in_data.cell_row, in_data.cell_col};
    mem_wd   = in_data.cell_value;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = 8'd0;
      end
      S_IDLE:  mem_we = in_acc && in_data.kind == KIND_WRITE;
      default: mem_we = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      pd_r        <= PD_W'(PD_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;
      if (state_r == S_CLEAR) clr_r <= clr_r + ADDR_W'(1);
      if (cfg_valid && cfg_ready) pd_r <= cfg_data;
      if (state_r == S_FIN && can_load) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  // map store
  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
    rd_r <= map_mem[rd_addr_c];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.kind == KIND_CAST) begin
          in_r   <= in_data;
          cx_r   <= $signed(24'(pd_r));
          cy_r   <= 24'(num_c);
          hhit_r <= 1'b0;
          vhit_r <= 1'b0;
          wsel_r <= 1'b0;
          hx_r <= '0; hy_r <= '0; vx_r <= '0; vy_r <= '0;
          hcont_r <= '0; vcont_r <= '0;
          if (num_c == '0) cz_r <= '0;
          else if (pd_r == '0) begin
            cz_r <= num_c[18] ? -$signed(17'(QUARTER_TURN)) : $signed(17'(QUARTER_TURN));
          end else cz_r <= '0;
        end
      end
      S_ATAN, S_SINCOS: begin
        cx_r <= x_n;
        cy_r <= y_n;
        cz_r <= z_n;
      end
      S_ANGLE: begin
        ang_r <= ang_c;
        cx_r  <= $signed(24'(CORDIC_START));
        cy_r  <= '0;
        cz_r  <= $signed({3'b0, ang_c[13:0]});
      end
      S_QUAD: begin
        ac_r <= ac_c; as_r <= as_c;
        down_r <= down_c; right_r <= right_c;
        hval_r <= hval_c; vval_r <= vval_c;
        yl_r <= yl_c; xl_r <= xl_c;
        dly_r <= dly_c; dlx_r <= dlx_c;
        job_r <= hval_c ? 2'd0 : 2'd2;
      end
      S_MUL: prod_r <= mul_p_c;
      S_DIVLD: begin
        dq_r   <= prod_r[29:0];
        drem_r <= '0;
      end
      S_DIV: begin
        dq_r   <= {dq_r[28:0], dge_c};
        drem_r <= rnew_c;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          case (job_r)
            2'd0:    xo_r <= {dq_r[28:0], dge_c};
            2'd1:    xs_r <= {dq_r[28:0], dge_c};
            2'd2:    yo_r <= {dq_r[28:0], dge_c};
            default: ys_r <= {dq_r[28:0], dge_c};
          endcase
          job_r <= job_r + 2'd1;
        end
      end
      S_WSET: begin
        if (!wsel_r && !hval_r) wsel_r <= 1'b1;
        else begin
          wx_r <= w_x0; wy_r <= w_y0;
          sx_r <= w_sx; sy_r <= w_sy;
        end
      end
      S_WCHK: begin
        oob_r <= !cell_in_c;
        if (!inb_c) wsel_r <= 1'b1;
      end
      S_WRD: begin
        if (cellv_c != 8'd0) begin
          wsel_r <= 1'b1;
          if (!wsel_r) begin
            hhit_r <= 1'b1; hx_r <= 20'(wx_r); hy_r <= 19'(wy_r); hcont_r <= cellv_c;
          end else begin
            vhit_r <= 1'b1; vx_r <= 20'(wx_r); vy_r <= 19'(wy_r); vcont_r <= cellv_c;
          end
        end else begin
          // advance to the next crossing
          wx_r <= wx_r + sx_r;
          wy_r <= wy_r + sy_r;
        end
      end
      S_SQ: begin
        prod_r <= mul_p_c;
        case (cnt_r[2:0])
          3'd1:    hd_r <= 41'(prod_r);
          3'd2:    hd_r <= hd_r + 41'(prod_r);
          3'd3:    vd_r <= 41'(prod_r);
          3'd4:    vd_r <= vd_r + 41'(prod_r);
          default: ;
        endcase
      end
      S_PICK: begin
        take_v_r <= !hhit_r || (vhit_r && vd_r < hd_r);
        sq_v_r   <= (!hhit_r || (vhit_r && vd_r < hd_r)) ? 42'(vd_r) : 42'(hd_r);
        sq_r_r   <= '0;
        sq_b_r   <= 42'(1) << SQRT_TOP;
      end
      S_SQRT: begin
        if (sq_ge_c) begin
          sq_v_r <= sq_v_r - sq_rb_c;
          sq_r_r <= (sq_r_r >> 1) + sq_b_r;
        end else sq_r_r <= sq_r_r >> 1;
        sq_b_r <= sq_b_r >> 2;
      end
      S_FIN: begin
        if (can_load) begin
          out_data_r.ray_angle <= ang_r;
          if (hhit_r || vhit_r) begin
            out_data_r.hit_found <= 1'b1;
            if (take_v_r) begin
              out_data_r.hit_x <= vx_r > 20'h7FFFF ? 19'h7FFFF : 19'(vx_r);
              out_data_r.hit_y <= vy_r > 19'h3FFFF ? 18'h3FFFF : 18'(vy_r);
              out_data_r.wall_content <= vcont_r;
            end else begin
              out_data_r.hit_x <= hx_r > 20'h7FFFF ? 19'h7FFFF : 19'(hx_r);
              out_data_r.hit_y <= hy_r > 19'h3FFFF ? 18'h3FFFF : 18'(hy_r);
              out_data_r.wall_content <= hcont_r;
            end
            out_data_r.hit_distance <= sq_r_r > 42'hFFFFF ? 20'hFFFFF : 20'(sq_r_r);
            out_data_r.vert_side <= take_v_r;
          end else begin
            out_data_r.hit_found    <= 1'b0;
            out_data_r.hit_x        <= '0;
            out_data_r.hit_y        <= '0;
            out_data_r.hit_distance <= 20'hFFFFF;
            out_data_r.wall_content <= '0;
            out_data_r.vert_side    <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  `ASSERT_NXT(a_cast_busy, in_valid && !in_stall && in_data.kind == KIND_CAST, in_stall)
  `ASSERT_IMP(a_nohit_dist, out_valid && !out_data.hit_found, out_data.hit_distance == 20'hFFFFF)
  `ASSERT_IMP(a_hit_content, out_valid && out_data.hit_found, out_data.wall_content != 8'd0)

endmodule
